// File: hw/rtl/sssm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssm_pkg: shared definitions for the component slot map
// Sizes, field widths, op and status codes, sequencer states and the
// structs passed between the slot map modules.
// ----------------------------------------------------------------------------
package sssm_pkg;

  // Store geometry
  localparam int COMPONENT_TYPES = 8;
  localparam int ENTITIES        = 256;
  localparam int SLOTS_PER_TYPE  = 256;

  localparam int TYPE_W = (COMPONENT_TYPES > 1) ? $clog2(COMPONENT_TYPES) : 1;
  localparam int ENT_W  = $clog2(ENTITIES);
  localparam int SLOT_W = (SLOTS_PER_TYPE > 1) ? $clog2(SLOTS_PER_TYPE) : 1;
  localparam int CNT_W  = $clog2(SLOTS_PER_TYPE + 1);

  // Port field widths
  localparam int MASK_W   = 8;
  localparam int OP_W     = 2;
  localparam int EIDX_W   = 8;
  localparam int TIDX_W   = 3;
  localparam int STATUS_W = 3;
  localparam int OSLOT_W  = 8;
  localparam int BITS_W   = 8;
  localparam int OENT_W   = 8;

  // Op codes (any other code acts as a lookup)
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_MOVE,
    S_DONE
  } state_e;

  // One lane of an entity row: mapping of that entity for one type
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } e2s_entry_t;

  typedef e2s_entry_t [COMPONENT_TYPES-1:0] e2s_row_t;

  // Memory access request from the sequencer
  typedef struct packed {
    logic              e2s_re;
    logic [ENT_W-1:0]  e2s_raddr;
    logic              e2s_we;
    logic [ENT_W-1:0]  e2s_waddr;
    logic [TYPE_W-1:0] e2s_wlane;
    e2s_entry_t        e2s_wdata;
    logic              s2e_re;
    logic [TYPE_W-1:0] s2e_rtype;
    logic [SLOT_W-1:0] s2e_rslot;
    logic              s2e_we;
    logic [TYPE_W-1:0] s2e_wtype;
    logic [SLOT_W-1:0] s2e_wslot;
    logic [ENT_W-1:0]  s2e_wdata;
  } map_req_t;

  // Configuration state seen by the sequencer
  typedef struct packed {
    logic [MASK_W-1:0]          mask;
    logic [COMPONENT_TYPES-1:0] siu_clr;
    logic                       sweep_busy;
  } cfg_ctl_t;

  // One result transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OSLOT_W-1:0]  slot;
    logic [BITS_W-1:0]   type_bits;
    logic                moved;
    logic [OSLOT_W-1:0]  move_from_slot;
    logic [OENT_W-1:0]   moved_entity;
  } res_t;

endpackage

// File: hw/rtl/sssm_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssm_req_if: request channel
// Valid/ready channel carrying one access (op, entity, type).
// ----------------------------------------------------------------------------
interface sssm_req_if;
  import sssm_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [EIDX_W-1:0] ent_idx;
  logic [TIDX_W-1:0] type_index;

  modport source (output valid, output op, output ent_idx, output type_index,
                  input ready);
  modport sink   (input valid, input op, input ent_idx, input type_index,
                  output ready);
endinterface

// File: hw/rtl/sssm_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssm_rsp_if: result channel
// Valid/ready channel carrying one access result.
// ----------------------------------------------------------------------------
interface sssm_rsp_if;
  import sssm_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OSLOT_W-1:0]  slot;
  logic [BITS_W-1:0]   type_bits;
  logic                moved;
  logic [OSLOT_W-1:0]  move_from_slot;
  logic [OENT_W-1:0]   moved_entity;

  modport source (output valid, output status, output slot, output type_bits,
                  output moved, output move_from_slot, output moved_entity,
                  input ready);
  modport sink   (input valid, input status, input slot, input type_bits,
                  input moved, input move_from_slot, input moved_entity,
                  output ready);
endinterface

// File: hw/rtl/sparse_set_component_slot_map_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_set_component_slot_map_top: per-type sparse set slot map
// Packed entity-to-slot maps with swap-remove, per-entity type bitmaps,
// type enable register with clear-on-enable sweeps.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  : valid/ready request channel (op, ent_idx, type_index).
//   rsp_o  : valid/ready result channel, one result transaction per request.
//   cfg_we_i / cfg_wdata_i : type enable mask write, one cycle, no read-back.
// Timing: a request is accepted in IDLE, the entity row is read, then the
//   maps are evaluated and updated in EVAL; a remove that swaps the last
//   slot in adds a MOVE step, and DONE loads the result into the output
//   register. The next request is taken the cycle after the result is
//   loaded, so the block takes no new request until the last one is
//   through; a clearing sweep also holds requests off.
// Reset: all types are swept clean, one entity lane per cycle, 256 lanes
//   per type with a turnaround between types, with ready low. Enabling
//   a type (0 to 1) clears its slot count at once and sweeps that type's
//   lanes, ready low.
// Stall: a held result sits in the output register; one more request can be
//   accepted and worked up to the point of loading, where it waits.
// ----------------------------------------------------------------------------
module sparse_set_component_slot_map_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sssm_pkg::MASK_W-1:0] cfg_wdata_i,
  sssm_req_if.sink                    req_i,
  sssm_rsp_if.source                  rsp_o
);
  import sssm_pkg::*;

  logic [MASK_W-1:0]          mask_q;
  logic [MASK_W-1:0]          rising;
  logic [COMPONENT_TYPES-1:0] rise_ct;
  logic [COMPONENT_TYPES-1:0] pend_q, pend_d;
  logic                       clr_active_q;
  logic [TYPE_W-1:0]          clr_type_q;
  logic [ENT_W-1:0]           clr_ent_q;
  logic                       clr_last;
  logic [TYPE_W-1:0]          pick;

  cfg_ctl_t   cfg_ctl;
  map_req_t   ctrl_req, map_req;
  e2s_row_t   e2s_rdata;
  logic [ENT_W-1:0] s2e_rdata;

  // Enable bits going 0 -> 1 on this write
  assign rising  = cfg_we_i ? (cfg_wdata_i & ~mask_q) : '0;
  assign rise_ct = COMPONENT_TYPES'(rising);

  assign clr_last = clr_active_q && (clr_ent_q == ENT_W'(ENTITIES - 1));

  // A type's pending bit drops once its sweep finishes; a new enable re-arms it
  always_comb begin
    pend_d = pend_q;
    if (clr_last) begin
      pend_d = pend_q & ~(COMPONENT_TYPES'(1) << clr_type_q);
    end
    pend_d = pend_d | rise_ct;
  end

  // Lowest pending type is swept next
  always_comb begin
    pick = '0;
    for (int i = COMPONENT_TYPES - 1; i >= 0; i--) begin
      if (pend_q[i]) pick = TYPE_W'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q       <= '0;
      pend_q       <= '1;
      clr_active_q <= 1'b0;
      clr_type_q   <= '0;
      clr_ent_q    <= '0;
    end else begin
      if (cfg_we_i) mask_q <= cfg_wdata_i;
      pend_q <= pend_d;
      if (clr_active_q) begin
        clr_ent_q <= clr_ent_q + ENT_W'(1);
        if (clr_last) clr_active_q <= 1'b0;
      end else if (|pend_q) begin
        clr_active_q <= 1'b1;
        clr_type_q   <= pick;
        clr_ent_q    <= '0;
      end
    end
  end

  assign cfg_ctl.mask       = mask_q;
  assign cfg_ctl.siu_clr    = rise_ct;
  assign cfg_ctl.sweep_busy = |pend_q;

  // Sweep owns the row write port while active; the sequencer is held off
  always_comb begin
    map_req = ctrl_req;
    if (clr_active_q) begin
      map_req.e2s_we    = 1'b1;
      map_req.e2s_waddr = clr_ent_q;
      map_req.e2s_wlane = clr_type_q;
      map_req.e2s_wdata = '0;
    end
  end

  sssm_maps u_maps (
    .clk_i       (clk_i),
    .req_i       (map_req),
    .e2s_rdata_o (e2s_rdata),
    .s2e_rdata_o (s2e_rdata)
  );

  sssm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_ctl),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .map_req_o   (ctrl_req),
    .e2s_rdata_i (e2s_rdata),
    .s2e_rdata_i (s2e_rdata)
  );

  a_sweep_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !ctrl_req.e2s_we && !ctrl_req.e2s_re && !req_i.ready)
    else $error("map access during clearing sweep");

  a_sweep_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> pend_q[clr_type_q])
    else $error("sweeping a type with no pending clear");

endmodule

// File: hw/rtl/sssm_maps.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssm_maps: entity/slot map memories
// Entity rows (one lane per type, lane write enable) and the per-type
// slot-to-entity table. Registered reads.
// ----------------------------------------------------------------------------
module sssm_maps (
  input  logic                          clk_i,
  input  sssm_pkg::map_req_t            req_i,
  output sssm_pkg::e2s_row_t            e2s_rdata_o,
  output logic [sssm_pkg::ENT_W-1:0]    s2e_rdata_o
);
  import sssm_pkg::*;

  e2s_row_t         e2s_mem [ENTITIES];
  logic [ENT_W-1:0] s2e_mem [COMPONENT_TYPES][SLOTS_PER_TYPE];

  always_ff @(posedge clk_i) begin
    if (req_i.e2s_we) begin
      e2s_mem[req_i.e2s_waddr][req_i.e2s_wlane] <= req_i.e2s_wdata;
    end
    if (req_i.e2s_re) begin
      e2s_rdata_o <= e2s_mem[req_i.e2s_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.s2e_we) begin
      s2e_mem[req_i.s2e_wtype][req_i.s2e_wslot] <= req_i.s2e_wdata;
    end
    if (req_i.s2e_re) begin
      s2e_rdata_o <= s2e_mem[req_i.s2e_rtype][req_i.s2e_rslot];
    end
  end

endmodule

// File: hw/rtl/sssm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssm_ctrl: access sequencer
// Steps one access through row read, evaluate/update and the optional
// swap move; owns slots-in-use counters and the output register.
// ----------------------------------------------------------------------------
module sssm_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sssm_pkg::cfg_ctl_t         cfg_i,
  sssm_req_if.sink                   req_i,
  sssm_rsp_if.source                 rsp_o,
  output sssm_pkg::map_req_t         map_req_o,
  input  sssm_pkg::e2s_row_t         e2s_rdata_i,
  input  logic [sssm_pkg::ENT_W-1:0] s2e_rdata_i
);
  import sssm_pkg::*;

  state_e state_q, state_d;

  logic [OP_W-1:0]   op_q;
  logic [EIDX_W-1:0] eidx_q;
  logic [TIDX_W-1:0] tidx_q;
  logic [SLOT_W-1:0] slot_q, last_q;
  logic [CNT_W-1:0]  siu_q [COMPONENT_TYPES];
  res_t              res_q, res_d;
  res_t              out_q;
  logic              out_valid_q;

  logic                       accept, out_free, need_move, save_move, siu_we;
  logic [CNT_W-1:0]           siu_wdata, siu_cur;
  logic                       type_ok, ent_ok;
  logic [TYPE_W-1:0]          tsel;
  e2s_entry_t                 cur;
  logic [COMPONENT_TYPES-1:0] vbits, tbit;

  assign req_i.ready = (state_q == S_IDLE) && !cfg_i.sweep_busy;
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign tsel    = TYPE_W'(tidx_q);
  assign type_ok = (int'(tidx_q) < COMPONENT_TYPES) && cfg_i.mask[tidx_q];
  assign ent_ok  = int'(eidx_q) < ENTITIES;
  assign cur     = e2s_rdata_i[tsel];
  assign tbit    = COMPONENT_TYPES'(1) << tsel;
  assign siu_cur = siu_q[tsel];

  always_comb begin
    for (int i = 0; i < COMPONENT_TYPES; i++) begin
      vbits[i] = e2s_rdata_i[i].valid;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_EVAL;
      S_EVAL: state_d = need_move ? S_MOVE : S_DONE;
      S_MOVE: state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs: memory requests, result, counter update
  always_comb begin
    map_req_o = '0;
    res_d     = res_q;
    siu_we    = 1'b0;
    siu_wdata = siu_cur;
    need_move = 1'b0;
    save_move = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        map_req_o.e2s_re    = accept;
        map_req_o.e2s_raddr = ENT_W'(req_i.ent_idx);
      end
      S_EVAL: begin
        res_d        = '0;
        res_d.status = ST_ABSENT;
        if (!type_ok) begin
          res_d.status = ST_DISABLED;
          if (ent_ok) res_d.type_bits = BITS_W'(vbits);
        end else if (ent_ok) begin
          res_d.type_bits = BITS_W'(vbits);
          if (op_q == OP_ADD) begin
            if (cur.valid) begin
              res_d.status = ST_PRESENT;
              res_d.slot   = OSLOT_W'(cur.slot);
            end else if (siu_cur >= CNT_W'(SLOTS_PER_TYPE)) begin
              res_d.status = ST_FULL;
            end else begin
              res_d.status    = ST_ADDED;
              res_d.slot      = OSLOT_W'(siu_cur);
              res_d.type_bits = BITS_W'(vbits | tbit);
              siu_we          = 1'b1;
              siu_wdata       = siu_cur + CNT_W'(1);
              map_req_o.e2s_we          = 1'b1;
              map_req_o.e2s_waddr       = ENT_W'(eidx_q);
              map_req_o.e2s_wlane       = tsel;
              map_req_o.e2s_wdata.valid = 1'b1;
              map_req_o.e2s_wdata.slot  = SLOT_W'(siu_cur);
              map_req_o.s2e_we          = 1'b1;
              map_req_o.s2e_wtype       = tsel;
              map_req_o.s2e_wslot       = SLOT_W'(siu_cur);
              map_req_o.s2e_wdata       = ENT_W'(eidx_q);
            end
          end else if (op_q == OP_REMOVE) begin
            if (cur.valid && (siu_cur != '0)) begin
              res_d.status    = ST_PRESENT;
              res_d.slot      = OSLOT_W'(cur.slot);
              res_d.type_bits = BITS_W'(vbits & ~tbit);
              siu_we          = 1'b1;
              siu_wdata       = siu_cur - CNT_W'(1);
              map_req_o.e2s_we    = 1'b1;
              map_req_o.e2s_waddr = ENT_W'(eidx_q);
              map_req_o.e2s_wlane = tsel;
              // freed slot not the last one: fetch the last slot's owner
              if (cur.slot != SLOT_W'(siu_wdata)) begin
                need_move           = 1'b1;
                save_move           = 1'b1;
                map_req_o.s2e_re    = 1'b1;
                map_req_o.s2e_rtype = tsel;
                map_req_o.s2e_rslot = SLOT_W'(siu_wdata);
              end
            end
          end else begin
            if (cur.valid) begin
              res_d.status = ST_PRESENT;
              res_d.slot   = OSLOT_W'(cur.slot);
            end
          end
        end
      end
      S_MOVE: begin
        map_req_o.e2s_we          = 1'b1;
        map_req_o.e2s_waddr       = s2e_rdata_i;
        map_req_o.e2s_wlane       = tsel;
        map_req_o.e2s_wdata.valid = 1'b1;
        map_req_o.e2s_wdata.slot  = slot_q;
        map_req_o.s2e_we          = 1'b1;
        map_req_o.s2e_wtype       = tsel;
        map_req_o.s2e_wslot       = slot_q;
        map_req_o.s2e_wdata       = s2e_rdata_i;
        res_d.moved               = 1'b1;
        res_d.move_from_slot      = OSLOT_W'(last_q);
        res_d.moved_entity        = OENT_W'(s2e_rdata_i);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < COMPONENT_TYPES; i++) begin
        siu_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      for (int i = 0; i < COMPONENT_TYPES; i++) begin
        if (cfg_i.siu_clr[i]) begin
          siu_q[i] <= '0;
        end else if (siu_we && (tsel == TYPE_W'(i))) begin
          siu_q[i] <= siu_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= req_i.op;
      eidx_q <= req_i.ent_idx;
      tidx_q <= req_i.type_index;
    end
    res_q <= res_d;
    if (save_move) begin
      slot_q <= cur.slot;
      last_q <= SLOT_W'(siu_wdata);
    end
    if ((state_q == S_DONE) && out_free) begin
      out_q <= res_q;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_q.status;
  assign rsp_o.slot           = out_q.slot;
  assign rsp_o.type_bits      = out_q.type_bits;
  assign rsp_o.moved          = out_q.moved;
  assign rsp_o.move_from_slot = out_q.move_from_slot;
  assign rsp_o.moved_entity   = out_q.moved_entity;

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EVAL)
    else $error("accepted transaction did not enter evaluation");

  a_move_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MOVE |-> (op_q == OP_REMOVE) && ($past(state_q) == S_EVAL))
    else $error("swap move outside a remove");

  a_siu_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL |-> siu_cur <= CNT_W'(SLOTS_PER_TYPE))
    else $error("slots in use exceeds capacity");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && out_valid_q && !rsp_o.ready |=> state_q == S_DONE)
    else $error("result left done while output register full");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the component slot map
// Drives add, remove and lookup transactions through the request channel and
// predicts every result with a local copy of the per-type sparse sets,
// including swap-on-remove and the clear that follows enabling a type. The
// mask register is rewritten between phases while the block is quiet. Both
// channel sides idle at random; the result side holds off for long stretches.
// ----------------------------------------------------------------------------
module tb;
  import sssm_pkg::*;

  // Op code 3 is not named in the package; the block treats it as a lookup.
  localparam logic [OP_W-1:0] OP_LOOKUP_ALT = 2'd3;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD   = 200;
  localparam int MAX_LINES   = 60;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [EIDX_W-1:0] ent;
    logic [TIDX_W-1:0] ty;
  } access_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [MASK_W-1:0] cfg_wdata_i;

  sssm_req_if req_if ();
  sssm_rsp_if rsp_if ();

  sparse_set_component_slot_map_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Local copy of the slot maps. Everything starts at zero, as after reset.
  // --------------------------------------------------------------------------
  bit [MASK_W-1:0] mask_q;
  bit              held_q    [COMPONENT_TYPES][ENTITIES];
  bit [7:0]        slot_of_q [COMPONENT_TYPES][ENTITIES];
  bit [7:0]        owner_q   [COMPONENT_TYPES][SLOTS_PER_TYPE];
  int              fill_q    [COMPONENT_TYPES];
  bit [7:0]        bits_q    [ENTITIES];

  access_t access_q[$];          // transactions waiting for the driver
  res_t    access_results_q[$];  // results owed by the block, oldest first

  int err_cnt     = 0;
  int n_results   = 0;
  int n_cfg       = 0;
  int n_swaps     = 0;
  int n_status[5] = '{default: 0};
  int cycle_cnt   = 0;
  int drv_wait    = 0;
  int drv_calm    = 0;
  int mon_hold    = 0;
  int mon_calm    = 0;

  // Writing the mask: a bit that goes 0 -> 1 wipes that type's set and
  // drops the type from every entity's bitmap.
  function automatic void apply_mask(input logic [MASK_W-1:0] nv);
    logic [MASK_W-1:0] rising;
    rising = nv & ~mask_q;
    for (int t = 0; t < COMPONENT_TYPES; t++) begin
      if (rising[t]) begin
        fill_q[t] = 0;
        for (int e = 0; e < ENTITIES; e++) begin
          held_q[t][e]    = 1'b0;
          slot_of_q[t][e] = '0;
          bits_q[e][t]    = 1'b0;
        end
      end
    end
    mask_q = nv;
  endfunction

  // One access against the local maps: returns the result the block owes
  // and updates the maps the same way.
  function automatic res_t apply_access(input access_t a);
    res_t r;
    int   last;
    logic [7:0] le;
    r           = '0;
    r.status    = ST_ABSENT;
    r.type_bits = bits_q[a.ent];
    if (!mask_q[a.ty]) begin
      r.status = ST_DISABLED;
    end else begin
      if (a.op == OP_ADD) begin
        if (held_q[a.ty][a.ent]) begin
          r.status = ST_PRESENT;
          r.slot   = slot_of_q[a.ty][a.ent];
        end else if (fill_q[a.ty] >= SLOTS_PER_TYPE) begin
          r.status = ST_FULL;
        end else begin
          r.slot                   = OSLOT_W'(fill_q[a.ty]);
          fill_q[a.ty]             = fill_q[a.ty] + 1;
          held_q[a.ty][a.ent]      = 1'b1;
          slot_of_q[a.ty][a.ent]   = r.slot;
          owner_q[a.ty][r.slot]    = a.ent;
          bits_q[a.ent][a.ty]      = 1'b1;
          r.status                 = ST_ADDED;
        end
      end else if (a.op == OP_REMOVE) begin
        if (held_q[a.ty][a.ent] && fill_q[a.ty] > 0) begin
          last                   = fill_q[a.ty] - 1;
          r.slot                 = slot_of_q[a.ty][a.ent];
          held_q[a.ty][a.ent]    = 1'b0;
          slot_of_q[a.ty][a.ent] = '0;
          fill_q[a.ty]           = last;
          // Swap-remove: the last slot's owner moves into the hole.
          if (int'(r.slot) != last) begin
            le                    = owner_q[a.ty][last];
            slot_of_q[a.ty][le]   = r.slot;
            owner_q[a.ty][r.slot] = le;
            r.moved               = 1'b1;
            r.move_from_slot      = OSLOT_W'(last);
            r.moved_entity        = le;
          end
          bits_q[a.ent][a.ty] = 1'b0;
          r.status            = ST_PRESENT;
        end
      end else if (held_q[a.ty][a.ent]) begin
        r.status = ST_PRESENT;
        r.slot   = slot_of_q[a.ty][a.ent];
      end
      r.type_bits = bits_q[a.ent];
    end
    return r;
  endfunction

  // Idle length per transaction, with runs of back-to-back traffic mixed in.
  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_LINES) $display("ERROR @%0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d field %s got %0d want %0d",
                                n_results, name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Run limit
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timed out with %0d results outstanding", access_results_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request driver: pops the queue, idles a random number of cycles between
  // transactions, and records the owed result at the accepting edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drv_blk
    access_t nxt;
    access_t cur;
    int      gap;
    if (!rst_ni) begin
      req_if.valid      <= 1'b0;
      req_if.op         <= OP_ADD;
      req_if.ent_idx    <= '0;
      req_if.type_index <= '0;
      drv_wait          <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        cur.op  = req_if.op;
        cur.ent = req_if.ent_idx;
        cur.ty  = req_if.type_index;
        access_results_q.push_back(apply_access(cur));
        gap = pick_wait(drv_calm);
        // Keep valid high across back-to-back transactions: one assignment.
        if (gap == 0 && access_q.size() != 0) begin
          nxt                = access_q.pop_front();
          req_if.op         <= nxt.op;
          req_if.ent_idx    <= nxt.ent;
          req_if.type_index <= nxt.ty;
        end else begin
          req_if.valid <= 1'b0;
          drv_wait     <= gap;
        end
      end else if (!req_if.valid) begin
        if (drv_wait > 0) begin
          drv_wait <= drv_wait - 1;
        end else if (access_q.size() != 0) begin
          nxt                = access_q.pop_front();
          req_if.valid      <= 1'b1;
          req_if.op         <= nxt.op;
          req_if.ent_idx    <= nxt.ent;
          req_if.type_index <= nxt.ty;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compares each accepted result with the oldest one owed,
  // then stalls ready at random. Twice it holds ready low for a long stretch so
  // the block backs up and drops request ready.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : mon_blk
    res_t want;
    int   h;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      mon_hold     <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (access_results_q.size() == 0) begin
          report_mismatch("result arrived with none outstanding");
        end else begin
          want = access_results_q.pop_front();
          check_field("status", int'(rsp_if.status), int'(want.status));
          check_field("slot", int'(rsp_if.slot), int'(want.slot));
          check_field("type_bits", int'(rsp_if.type_bits), int'(want.type_bits));
          check_field("moved", int'(rsp_if.moved), int'(want.moved));
          check_field("move_from_slot", int'(rsp_if.move_from_slot),
                      int'(want.move_from_slot));
          check_field("moved_entity", int'(rsp_if.moved_entity),
                      int'(want.moved_entity));
          if (want.status <= ST_FULL) n_status[want.status]++;
          if (want.moved) n_swaps++;
        end
        n_results++;
        h = pick_wait(mon_calm);
        if (n_results == 120 || n_results == 330) h = LONG_HOLD;
        if (h != 0) begin
          rsp_if.ready <= 1'b0;
          mon_hold     <= h;
        end
      end else if (!rsp_if.ready) begin
        if (mon_hold > 1) begin
          mon_hold <= mon_hold - 1;
        end else begin
          rsp_if.ready <= 1'b1;
          mon_hold     <= 0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_access(input logic [OP_W-1:0] op, input logic [EIDX_W-1:0] ent,
                              input logic [TIDX_W-1:0] ty);
    access_t a;
    a.op  = op;
    a.ent = ent;
    a.ty  = ty;
    access_q.push_back(a);
  endtask

  // Let every queued transaction go through and every result come back.
  task automatic drain();
    while (access_q.size() != 0 || access_results_q.size() != 0 || req_if.valid)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mask write, only ever issued with the block quiet. The short pause lets
  // an enable sweep start before new requests are offered.
  task automatic write_mask(input logic [MASK_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    apply_mask(v);
    n_cfg++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    repeat (3) @(posedge clk_i);
  endtask

  // Mostly a small pool of entities so adds and removes collide; the pool
  // is mirrored to the top of the range so the high bits toggle too.
  function automatic logic [EIDX_W-1:0] pick_entity();
    logic [EIDX_W-1:0] e;
    if ($urandom_range(0, 3) == 0) return EIDX_W'($urandom_range(0, 255));
    e = EIDX_W'($urandom_range(0, 11));
    if ($urandom_range(0, 1)) e = e ^ 8'hF0;
    return e;
  endfunction

  function automatic logic [TIDX_W-1:0] pick_type();
    int t;
    if (mask_q == '0 || $urandom_range(0, 4) == 0) return TIDX_W'($urandom_range(0, 7));
    do t = $urandom_range(0, 7); while (!mask_q[t]);
    return TIDX_W'(t);
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return OP_ADD;
    if (r < 7) return OP_REMOVE;
    if (r < 9) return OP_LOOKUP;
    return OP_LOOKUP_ALT;
  endfunction

  task automatic mixed_phase(input logic [MASK_W-1:0] m, input int n);
    write_mask(m);
    for (int i = 0; i < n; i++) queue_access(pick_op(), pick_entity(), pick_type());
    drain();
  endtask

  // Fill one type to capacity in a random order, then hit it while full,
  // tear part of it down with swap-removes, and refill a few.
  task automatic fill_phase();
    int order[ENTITIES];
    int j;
    int tmp;
    logic [TIDX_W-1:0] ft;
    ft = TIDX_W'($urandom_range(0, 7));
    write_mask(mask_q & ~(8'h01 << ft));
    write_mask(mask_q | (8'h01 << ft));
    for (int i = 0; i < ENTITIES; i++) order[i] = i;
    for (int i = ENTITIES - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < ENTITIES; i++) queue_access(OP_ADD, EIDX_W'(order[i]), ft);
    for (int i = 0; i < 20; i++)
      queue_access(OP_ADD, EIDX_W'($urandom_range(0, 255)), ft);
    for (int i = 0; i < 10; i++)
      queue_access(OP_LOOKUP, EIDX_W'($urandom_range(0, 255)), ft);
    for (int i = 0; i < 40; i++)
      queue_access(OP_REMOVE, EIDX_W'($urandom_range(0, 255)), ft);
    for (int i = 0; i < 15; i++) begin
      if ($urandom_range(0, 2) == 0)
        queue_access(OP_LOOKUP, EIDX_W'($urandom_range(0, 255)), ft);
      else queue_access(OP_ADD, EIDX_W'($urandom_range(0, 255)), ft);
    end
    drain();
  endtask

  initial begin : stim
    // Every block input known from time zero.
    req_if.valid      = 1'b0;
    req_if.op         = OP_ADD;
    req_if.ent_idx    = '0;
    req_if.type_index = '0;
    rsp_if.ready      = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    rst_ni            = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Nothing enabled yet: every access reports a disabled type. These also
    // sit behind the clearing pass after reset.
    queue_access(OP_ADD, 8'd0, 3'd0);
    queue_access(OP_REMOVE, 8'd255, 3'd7);
    queue_access(OP_LOOKUP_ALT, 8'd0, 3'd0);
    drain();

    // All types on: add, re-add, lookups, swap and no-swap removes.
    write_mask(8'hFF);
    queue_access(OP_ADD, 8'd0, 3'd0);
    queue_access(OP_ADD, 8'd255, 3'd0);
    queue_access(OP_ADD, 8'd0, 3'd0);          // already present
    queue_access(OP_LOOKUP, 8'd255, 3'd0);
    queue_access(OP_LOOKUP, 8'd1, 3'd0);       // never added
    queue_access(OP_LOOKUP_ALT, 8'd0, 3'd0);
    queue_access(OP_ADD, 8'd255, 3'd7);
    queue_access(OP_ADD, 8'd0, 3'd7);
    queue_access(OP_REMOVE, 8'd0, 3'd0);       // slot 0 freed, 255 moves in
    queue_access(OP_REMOVE, 8'd255, 3'd0);     // last slot, nothing moves
    queue_access(OP_REMOVE, 8'd255, 3'd0);     // gone already
    queue_access(OP_REMOVE, 8'd0, 3'd7);       // holds the last slot
    queue_access(OP_ADD, 8'd128, 3'd3);
    queue_access(OP_ADD, 8'd127, 3'd3);
    queue_access(OP_REMOVE, 8'd128, 3'd3);
    drain();

    // Disabling only blocks access; type 3 stays enabled and keeps its contents.
    write_mask(8'h5A);
    queue_access(OP_LOOKUP, 8'd127, 3'd3);
    queue_access(OP_ADD, 8'd0, 3'd0);
    drain();

    // Re-enabling 0, 2, 5 and 7 wipes them.
    write_mask(8'hA5);
    queue_access(OP_LOOKUP, 8'd255, 3'd7);
    queue_access(OP_LOOKUP, 8'd127, 3'd3);
    queue_access(OP_ADD, 8'd0, 3'd0);
    drain();

    // Random part.
    mixed_phase(MASK_W'($urandom_range(0, 255)), 35);
    mixed_phase(8'hFF, 35);
    mixed_phase(MASK_W'($urandom_range(0, 255)), 35);
    fill_phase();

    repeat (10) @(posedge clk_i);
    if (access_results_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", access_results_q.size()));

    $display("Checked %0d results across %0d mask writes, %0d swap-removes",
             n_results, n_cfg, n_swaps);
    $display("Status mix: added %0d, present %0d, absent %0d, disabled %0d, full %0d",
             n_status[ST_ADDED], n_status[ST_PRESENT], n_status[ST_ABSENT],
             n_status[ST_DISABLED], n_status[ST_FULL]);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
